@@ rtl/rmf_pkg.sv @@
// rmf_pkg: shared types, mode and drive codes, register map and reset
// values for the robot mode controller. No dependencies.
`default_nettype none

package rmf_pkg;

    typedef logic [3:0]  t_mode;
    typedef logic [1:0]  t_drive;
    typedef logic [1:0]  t_button;
    typedef logic [15:0] t_level;
    typedef logic [7:0]  t_reg_index;

    // mode codes
    localparam t_mode MODE_INACTIVE = 4'd0;
    localparam t_mode MODE_NORMAL   = 4'd1;
    localparam t_mode MODE_SLOW     = 4'd2;
    localparam t_mode MODE_DARK     = 4'd3;
    localparam t_mode MODE_BUMPED   = 4'd4;
    localparam t_mode MODE_RISING   = 4'd5;
    localparam t_mode MODE_RISESTOP = 4'd6;
    localparam t_mode MODE_HELD     = 4'd7;
    localparam t_mode MODE_LOWERING = 4'd8;
    localparam t_mode MODE_LOWERED  = 4'd9;

    // drive commands
    localparam t_drive DRV_STOP = 2'd0;
    localparam t_drive DRV_FULL = 2'd1;
    localparam t_drive DRV_SLOW = 2'd2;

    // button codes
    localparam t_button BTN_START = 2'd1;
    localparam t_button BTN_STOP  = 2'd2;

    // register indexes
    localparam t_reg_index REG_LIGHT_OUT   = 8'd0;
    localparam t_reg_index REG_LIGHT_DIM   = 8'd1;
    localparam t_reg_index REG_LIFT_START  = 8'd2;
    localparam t_reg_index REG_LIFT_PEAK   = 8'd3;
    localparam t_reg_index REG_LIFT_SETTLE = 8'd4;
    localparam t_reg_index REG_DROP_START  = 8'd5;
    localparam t_reg_index REG_DROP_PEAK   = 8'd6;
    localparam t_reg_index REG_DROP_SETTLE = 8'd7;

    typedef struct packed {
        t_level light_out;
        t_level light_dim;
        t_level lift_start;
        t_level lift_peak;
        t_level lift_settle;
        t_level drop_start;
        t_level drop_peak;
        t_level drop_settle;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        light_out:   16'd20,
        light_dim:   16'd100,
        lift_start:  16'd17000,
        lift_peak:   16'd15300,
        lift_settle: 16'd16300,
        drop_start:  16'd15300,
        drop_peak:   16'd17000,
        drop_settle: 16'd16500
    };

    typedef struct packed {
        t_button button_code;
        logic    bump_hit;
        t_level  light_level;
        t_level  accel_vertical;
    } t_sample;

endpackage

`default_nettype wire

@@ rtl/rmf_ifs.sv @@
// rmf_ifs: valid/ready channel interfaces for samples, results and
// register writes. Depends on rmf_pkg.
`default_nettype none

interface rmf_sample_if;
    logic               valid;
    logic               ready;
    rmf_pkg::t_button   button_code;
    logic               bump_hit;
    rmf_pkg::t_level    light_level;
    rmf_pkg::t_level    accel_vertical;

    modport source (output valid, button_code, bump_hit, light_level, accel_vertical,
                    input ready);
    modport sink   (input valid, button_code, bump_hit, light_level, accel_vertical,
                    output ready);
endinterface

interface rmf_result_if;
    logic               valid;
    logic               ready;
    rmf_pkg::t_mode     mode;
    rmf_pkg::t_drive    drive_command;

    modport source (output valid, mode, drive_command, input ready);
    modport sink   (input valid, mode, drive_command, output ready);
endinterface

interface rmf_cfg_if;
    logic                  valid;
    logic                  ready;
    rmf_pkg::t_reg_index   index;
    rmf_pkg::t_level       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/rmf_next.sv @@
// rmf_next: next-mode and drive decision for one sample.
// Depends on rmf_pkg.
`default_nettype none

module rmf_next (
    input  wire rmf_pkg::t_mode   i_cur_mode,
    input  wire rmf_pkg::t_sample i_sample,
    input  wire rmf_pkg::t_cfg    i_cfg,
    output rmf_pkg::t_mode        o_mode,
    output rmf_pkg::t_drive       o_drive
);

    rmf_pkg::t_mode cur;
    rmf_pkg::t_mode band;
    rmf_pkg::t_mode nxt;
    rmf_pkg::t_level acc;
    logic bump;

    assign acc  = i_sample.accel_vertical;
    assign bump = i_sample.bump_hit;

    // light band: dark / slow / normal, strict compares
    always_comb begin
        if (i_sample.light_level < i_cfg.light_out) begin
            band = rmf_pkg::MODE_DARK;
        end else if (i_sample.light_level < i_cfg.light_dim) begin
            band = rmf_pkg::MODE_SLOW;
        end else begin
            band = rmf_pkg::MODE_NORMAL;
        end
    end

    // unused codes fold to inactive
    assign cur = (i_cur_mode > rmf_pkg::MODE_LOWERED) ? rmf_pkg::MODE_INACTIVE : i_cur_mode;

    always_comb begin
        nxt = cur;
        if (cur == rmf_pkg::MODE_INACTIVE) begin
            nxt = rmf_pkg::MODE_INACTIVE;
            if (i_sample.button_code == rmf_pkg::BTN_START) begin
                nxt = bump ? rmf_pkg::MODE_BUMPED : band;
            end
        end else if (i_sample.button_code == rmf_pkg::BTN_STOP) begin
            nxt = rmf_pkg::MODE_INACTIVE;
        end else begin
            case (cur)
                rmf_pkg::MODE_DARK: begin
                    nxt = band;
                end
                rmf_pkg::MODE_NORMAL, rmf_pkg::MODE_SLOW: begin
                    if (bump) begin
                        nxt = rmf_pkg::MODE_BUMPED;
                    end else if (acc > i_cfg.lift_start) begin
                        nxt = rmf_pkg::MODE_RISING;
                    end else begin
                        nxt = band;
                    end
                end
                rmf_pkg::MODE_BUMPED: begin
                    nxt = bump ? rmf_pkg::MODE_BUMPED : band;
                end
                rmf_pkg::MODE_RISING: begin
                    nxt = (acc < i_cfg.lift_peak) ? rmf_pkg::MODE_RISESTOP
                                                  : rmf_pkg::MODE_RISING;
                end
                rmf_pkg::MODE_RISESTOP: begin
                    nxt = (acc > i_cfg.lift_settle) ? rmf_pkg::MODE_HELD
                                                    : rmf_pkg::MODE_RISESTOP;
                end
                rmf_pkg::MODE_HELD: begin
                    nxt = (acc < i_cfg.drop_start) ? rmf_pkg::MODE_LOWERING
                                                   : rmf_pkg::MODE_HELD;
                end
                rmf_pkg::MODE_LOWERING: begin
                    nxt = (acc > i_cfg.drop_peak) ? rmf_pkg::MODE_LOWERED
                                                  : rmf_pkg::MODE_LOWERING;
                end
                rmf_pkg::MODE_LOWERED: begin
                    nxt = (acc < i_cfg.drop_settle) ? band : rmf_pkg::MODE_LOWERED;
                end
                default: begin
                    nxt = rmf_pkg::MODE_INACTIVE;
                end
            endcase
        end
    end

    assign o_mode = nxt;

    always_comb begin
        case (nxt)
            rmf_pkg::MODE_NORMAL: o_drive = rmf_pkg::DRV_FULL;
            rmf_pkg::MODE_SLOW:   o_drive = rmf_pkg::DRV_SLOW;
            default:              o_drive = rmf_pkg::DRV_STOP;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/robot_mode_fsm_light_tilt.sv @@
// robot_mode_fsm_light_tilt: top level of the robot mode controller.
// Depends on rmf_pkg, rmf_ifs (channel interfaces) and rmf_next.
`default_nettype none

//  channel    dir  word                                              handshake
//  i_sample   in   button_code, bump_hit, light_level, accel_vertical valid/ready
//  o_result   out  mode, drive_command                               valid/ready
//  i_cfg      in   index (8b), data (16b); index > 7 ignored         valid/ready
//
//  Two register stages: sample register, then result register. A word
//  moves on to o_result once the result register is free; throughput is
//  one word per clock absent stalls, limited by the single mode-update path.
//  The mode register advances when a word moves into the result register,
//  so words are decided strictly in order.
//  Either stage holds under output stall; input ready drops only when both
//  stages are full and the result is not being taken.
//  Synchronous active-low reset: stages empty, mode inactive, thresholds
//  back to their defaults. Config writes are always ready.

module robot_mode_fsm_light_tilt (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rmf_sample_if.sink    i_sample,
    rmf_result_if.source  o_result,
    rmf_cfg_if.sink       i_cfg
);

    // threshold registers
    rmf_pkg::t_cfg    r_cfg;
    rmf_pkg::t_cfg    n_cfg;

    // sample stage
    logic             r_s1_valid;
    rmf_pkg::t_sample r_s1_sample;

    // result stage and mode state
    logic             r_out_valid;
    rmf_pkg::t_mode   r_out_mode;
    rmf_pkg::t_drive  r_out_drive;
    rmf_pkg::t_mode   r_cur_mode;

    rmf_pkg::t_mode   n_mode;
    rmf_pkg::t_drive  n_drive;

    logic             out_free;   // result register can take a new word
    logic             s1_move;    // sample stage hands its word on
    logic             in_take;    // sample accepted this edge

    assign out_free = !r_out_valid || o_result.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign in_take  = i_sample.valid && i_sample.ready;

    assign i_sample.ready = !r_s1_valid || out_free;
    assign i_cfg.ready    = 1'b1;

    // ---- config writes ----
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                rmf_pkg::REG_LIGHT_OUT:   n_cfg.light_out   = i_cfg.data;
                rmf_pkg::REG_LIGHT_DIM:   n_cfg.light_dim   = i_cfg.data;
                rmf_pkg::REG_LIFT_START:  n_cfg.lift_start  = i_cfg.data;
                rmf_pkg::REG_LIFT_PEAK:   n_cfg.lift_peak   = i_cfg.data;
                rmf_pkg::REG_LIFT_SETTLE: n_cfg.lift_settle = i_cfg.data;
                rmf_pkg::REG_DROP_START:  n_cfg.drop_start  = i_cfg.data;
                rmf_pkg::REG_DROP_PEAK:   n_cfg.drop_peak   = i_cfg.data;
                rmf_pkg::REG_DROP_SETTLE: n_cfg.drop_settle = i_cfg.data;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= rmf_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---- sample stage ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_s1_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_sample.button_code    <= i_sample.button_code;
            r_s1_sample.bump_hit       <= i_sample.bump_hit;
            r_s1_sample.light_level    <= i_sample.light_level;
            r_s1_sample.accel_vertical <= i_sample.accel_vertical;
        end
    end

    // ---- mode decision ----
    rmf_next u_next (
        .i_cur_mode (r_cur_mode),
        .i_sample   (r_s1_sample),
        .i_cfg      (r_cfg),
        .o_mode     (n_mode),
        .o_drive    (n_drive)
    );

    // ---- result stage ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cur_mode  <= rmf_pkg::MODE_INACTIVE;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_cur_mode <= n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_mode  <= n_mode;
            r_out_drive <= n_drive;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.mode          = r_out_mode;
    assign o_result.drive_command = r_out_drive;

    // ---- checks ----
    // the word on display is always the mode the controller now holds
    a_out_is_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mode == r_cur_mode))
        else $error("result mode differs from held mode");

    // full speed exactly in normal, slow drive exactly in slow
    a_drive_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (((r_out_drive == rmf_pkg::DRV_FULL) ==
                          (r_out_mode == rmf_pkg::MODE_NORMAL)) &&
                         ((r_out_drive == rmf_pkg::DRV_SLOW) ==
                          (r_out_mode == rmf_pkg::MODE_SLOW))))
        else $error("drive command does not match mode");

    // state never leaves the defined code range
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_mode <= rmf_pkg::MODE_LOWERED)
        else $error("mode register out of range");

    // a stalled sample stage keeps its word
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_sample)))
        else $error("sample stage lost a word under stall");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for the robot mode controller (robot_mode_fsm_light_tilt).
// Depends on rmf_pkg, rmf_ifs and the RTL top. It drives sample words and register writes,
// predicts each mode/drive word and checks the words in order under random back-pressure.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // button codes with no request behind them
    localparam rmf_pkg::t_button    BTN_NONE    = 2'd0;
    localparam rmf_pkg::t_button    BTN_NONE_3  = 2'd3;
    // first index past the register map; writes there must be dropped
    localparam rmf_pkg::t_reg_index REG_COUNT   = 8'd8;
    // top of the index space, also outside the map
    localparam rmf_pkg::t_reg_index REG_FAR     = 8'hFF;
    localparam int                  CYCLE_LIMIT = 600000;
    localparam int                  MAX_REPORTS = 40;

    typedef struct packed {
        rmf_pkg::t_mode  mode;
        rmf_pkg::t_drive drive;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmf_sample_if sample_ch();
    rmf_result_if result_ch();
    rmf_cfg_if    cfg_ch();

    robot_mode_fsm_light_tilt u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: thresholds and mode as the block should hold them
    // ------------------------------------------------------------------
    rmf_pkg::t_cfg  thr;
    rmf_pkg::t_mode mode_now;
    t_outcome       modes_due[$];     // predicted words, oldest first

    int       errors;
    int       samples_sent;
    int       results_seen;
    int       reg_writes;
    int       cfg_sets;
    int       cycle_count;
    bit [15:0] modes_reached;

    // traffic knobs, flipped by the tests
    bit       tx_gaps_on;
    bit       rx_stalls_on;
    int       rx_hold_req;      // receiver picks this up and holds ready low that long

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // light bands, strict compares: dark below out level, slow below dim level
    function automatic rmf_pkg::t_mode light_band(rmf_pkg::t_level light);
        if (light < thr.light_out) return rmf_pkg::MODE_DARK;
        if (light < thr.light_dim) return rmf_pkg::MODE_SLOW;
        return rmf_pkg::MODE_NORMAL;
    endfunction

    function automatic rmf_pkg::t_mode next_mode(rmf_pkg::t_mode cur, rmf_pkg::t_sample s);
        rmf_pkg::t_mode nxt;
        nxt = cur;
        if (cur == rmf_pkg::MODE_INACTIVE || cur > rmf_pkg::MODE_LOWERED) begin
            // only a start leaves inactive; stop here changes nothing
            nxt = rmf_pkg::MODE_INACTIVE;
            if (s.button_code == rmf_pkg::BTN_START)
                nxt = s.bump_hit ? rmf_pkg::MODE_BUMPED : light_band(s.light_level);
        end else if (s.button_code == rmf_pkg::BTN_STOP) begin
            nxt = rmf_pkg::MODE_INACTIVE;
        end else begin
            case (cur)
                // dark looks at light only, bump ignored
                rmf_pkg::MODE_DARK: nxt = light_band(s.light_level);
                rmf_pkg::MODE_NORMAL, rmf_pkg::MODE_SLOW: begin
                    if (s.bump_hit)
                        nxt = rmf_pkg::MODE_BUMPED;
                    else if (s.accel_vertical > thr.lift_start)
                        nxt = rmf_pkg::MODE_RISING;
                    else
                        nxt = light_band(s.light_level);
                end
                rmf_pkg::MODE_BUMPED:
                    nxt = s.bump_hit ? rmf_pkg::MODE_BUMPED : light_band(s.light_level);
                rmf_pkg::MODE_RISING:
                    nxt = (s.accel_vertical < thr.lift_peak) ? rmf_pkg::MODE_RISESTOP
                                                             : rmf_pkg::MODE_RISING;
                rmf_pkg::MODE_RISESTOP:
                    nxt = (s.accel_vertical > thr.lift_settle) ? rmf_pkg::MODE_HELD
                                                               : rmf_pkg::MODE_RISESTOP;
                rmf_pkg::MODE_HELD:
                    nxt = (s.accel_vertical < thr.drop_start) ? rmf_pkg::MODE_LOWERING
                                                              : rmf_pkg::MODE_HELD;
                rmf_pkg::MODE_LOWERING:
                    nxt = (s.accel_vertical > thr.drop_peak) ? rmf_pkg::MODE_LOWERED
                                                             : rmf_pkg::MODE_LOWERING;
                default:
                    nxt = (s.accel_vertical < thr.drop_settle) ?
                          light_band(s.light_level) : rmf_pkg::MODE_LOWERED;
            endcase
        end
        return nxt;
    endfunction

    function automatic rmf_pkg::t_drive drive_of(rmf_pkg::t_mode m);
        if (m == rmf_pkg::MODE_NORMAL) return rmf_pkg::DRV_FULL;
        if (m == rmf_pkg::MODE_SLOW) return rmf_pkg::DRV_SLOW;
        return rmf_pkg::DRV_STOP;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // values around a threshold, the rails, or anything at all
    function automatic rmf_pkg::t_level near(rmf_pkg::t_level lvl);
        case ($urandom_range(0, 6))
            0:       return lvl - 16'd1;
            1:       return lvl;
            2:       return lvl + 16'd1;
            3:       return 16'h0000;
            4:       return 16'hFFFF;
            5:       return lvl + rmf_pkg::t_level'($urandom_range(0, 400)) - 16'd200;
            default: return rmf_pkg::t_level'($urandom);
        endcase
    endfunction

    function automatic rmf_pkg::t_button quiet_button();
        return $urandom_range(0, 1) ? BTN_NONE : BTN_NONE_3;
    endfunction

    function automatic rmf_pkg::t_sample sample_of(rmf_pkg::t_button b, logic bump,
                                                   rmf_pkg::t_level light,
                                                   rmf_pkg::t_level acc);
        rmf_pkg::t_sample s;
        s.button_code    = b;
        s.bump_hit       = bump;
        s.light_level    = light;
        s.accel_vertical = acc;
        return s;
    endfunction

    // Steered sample: aims the acceleration at the threshold that matters in the
    // predicted mode so pick-up / put-down sequences run through; noise is raw.
    function automatic rmf_pkg::t_sample make_sample(bit noise);
        rmf_pkg::t_sample s;
        rmf_pkg::t_level  acc_thr;
        int               r;
        if (noise)
            return sample_of(rmf_pkg::t_button'($urandom_range(0, 3)),
                             logic'($urandom_range(0, 1)),
                             rmf_pkg::t_level'($urandom), rmf_pkg::t_level'($urandom));
        r = $urandom_range(0, 99);
        if (mode_now == rmf_pkg::MODE_INACTIVE)
            s.button_code = (r < 60) ? rmf_pkg::BTN_START : quiet_button();
        else if (r < 3)
            s.button_code = rmf_pkg::BTN_STOP;
        else if (r < 5)
            s.button_code = rmf_pkg::BTN_START;
        else
            s.button_code = quiet_button();
        s.bump_hit = (mode_now == rmf_pkg::MODE_BUMPED) ? ($urandom_range(0, 1) == 1)
                                                         : ($urandom_range(0, 99) < 8);
        case ($urandom_range(0, 3))
            0:       s.light_level = near(thr.light_out);
            1:       s.light_level = near(thr.light_dim);
            2:       s.light_level = 16'hFFFF;
            default: s.light_level = rmf_pkg::t_level'($urandom);
        endcase
        case (mode_now)
            rmf_pkg::MODE_NORMAL, rmf_pkg::MODE_SLOW: acc_thr = thr.lift_start;
            rmf_pkg::MODE_RISING:                     acc_thr = thr.lift_peak;
            rmf_pkg::MODE_RISESTOP:                   acc_thr = thr.lift_settle;
            rmf_pkg::MODE_HELD:                       acc_thr = thr.drop_start;
            rmf_pkg::MODE_LOWERING:                   acc_thr = thr.drop_peak;
            rmf_pkg::MODE_LOWERED:                    acc_thr = thr.drop_settle;
            default:                                  acc_thr = rmf_pkg::t_level'($urandom);
        endcase
        s.accel_vertical = near(acc_thr);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------
    // Offer one word; valid stays high into the next word when there is no gap.
    task automatic send_sample(rmf_pkg::t_sample s);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.button_code    <= s.button_code;
        sample_ch.bump_hit       <= s.bump_hit;
        sample_ch.light_level    <= s.light_level;
        sample_ch.accel_vertical <= s.accel_vertical;
        do @(posedge i_clk); while (!sample_ch.ready);
        // accepted at this edge: advance the predicted mode
        mode_now = next_mode(mode_now, s);
        modes_due.push_back(t_outcome'{mode_now, drive_of(mode_now)});
        samples_sent++;
    endtask

    // Drop valid, wait for every predicted word, then let the pipe settle.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (modes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(rmf_pkg::t_reg_index idx, rmf_pkg::t_level value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
        case (idx)
            rmf_pkg::REG_LIGHT_OUT:   thr.light_out   = value;
            rmf_pkg::REG_LIGHT_DIM:   thr.light_dim   = value;
            rmf_pkg::REG_LIFT_START:  thr.lift_start  = value;
            rmf_pkg::REG_LIFT_PEAK:   thr.lift_peak   = value;
            rmf_pkg::REG_LIFT_SETTLE: thr.lift_settle = value;
            rmf_pkg::REG_DROP_START:  thr.drop_start  = value;
            rmf_pkg::REG_DROP_PEAK:   thr.drop_peak   = value;
            rmf_pkg::REG_DROP_SETTLE: thr.drop_settle = value;
            default: ;  // outside the map: block ignores it
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_cfg(rmf_pkg::t_cfg c);
        write_reg(rmf_pkg::REG_LIGHT_OUT,   c.light_out);
        write_reg(rmf_pkg::REG_LIGHT_DIM,   c.light_dim);
        write_reg(rmf_pkg::REG_LIFT_START,  c.lift_start);
        write_reg(rmf_pkg::REG_LIFT_PEAK,   c.lift_peak);
        write_reg(rmf_pkg::REG_LIFT_SETTLE, c.lift_settle);
        write_reg(rmf_pkg::REG_DROP_START,  c.drop_start);
        write_reg(rmf_pkg::REG_DROP_PEAK,   c.drop_peak);
        write_reg(rmf_pkg::REG_DROP_SETTLE, c.drop_settle);
        cfg_sets++;
    endtask

    // mostly steered words, one in ten raw noise
    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
            send_sample(make_sample($urandom_range(0, 9) == 0));
        drain_results();
    endtask

    task automatic note_error(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Walk every mode with the reset thresholds, hitting each compare at
    // equality and most also one past it, plus the ignored requests.
    task automatic test_directed_modes();
        rmf_pkg::t_sample seq[$];
        // stop while inactive
        seq.push_back(sample_of(rmf_pkg::BTN_STOP,  1'b0, 16'hFFFF, 16'h0000));
        seq.push_back(sample_of(BTN_NONE,           1'b1, 16'h0000, 16'hFFFF));
        seq.push_back(sample_of(BTN_NONE_3,         1'b0, 16'hFFFF, 16'hFFFF));
        // start into bumped
        seq.push_back(sample_of(rmf_pkg::BTN_START, 1'b1, 16'h0000, 16'h0000));
        seq.push_back(sample_of(BTN_NONE,           1'b1, 16'hFFFF, 16'hFFFF));
        seq.push_back(sample_of(BTN_NONE,           1'b0, thr.light_out - 16'd1, 16'h0000));
        // dark ignores bump; light at the out level is not dark
        seq.push_back(sample_of(BTN_NONE_3,         1'b1, thr.light_out, 16'hFFFF));
        // start while driving is ignored
        seq.push_back(sample_of(rmf_pkg::BTN_START, 1'b0, thr.light_dim - 16'd1, 16'h0000));
        seq.push_back(sample_of(BTN_NONE,           1'b0, thr.light_dim, thr.lift_start));
        seq.push_back(sample_of(BTN_NONE,           1'b0, 16'hFFFF, thr.lift_start + 16'd1));
        seq.push_back(sample_of(BTN_NONE,           1'b1, 16'h0000, thr.lift_peak));
        seq.push_back(sample_of(BTN_NONE,           1'b0, 16'h0000, thr.lift_peak - 16'd1));
        seq.push_back(sample_of(BTN_NONE,           1'b0, 16'hFFFF, thr.lift_settle));
        seq.push_back(sample_of(rmf_pkg::BTN_START, 1'b0, 16'hFFFF, 16'hFFFF));
        seq.push_back(sample_of(BTN_NONE,           1'b1, 16'h0000, thr.drop_start));
        seq.push_back(sample_of(BTN_NONE,           1'b0, 16'h0000, 16'h0000));
        seq.push_back(sample_of(BTN_NONE,           1'b0, 16'h0000, thr.drop_peak));
        seq.push_back(sample_of(BTN_NONE,           1'b0, 16'h0000, thr.drop_peak + 16'd1));
        seq.push_back(sample_of(BTN_NONE,           1'b0, 16'hFFFF, thr.drop_settle));
        seq.push_back(sample_of(BTN_NONE,           1'b0, thr.light_dim - 16'd1,
                                thr.drop_settle - 16'd1));
        seq.push_back(sample_of(rmf_pkg::BTN_STOP,  1'b0, 16'hFFFF, 16'hFFFF));
        seq.push_back(sample_of(rmf_pkg::BTN_START, 1'b0, 16'hFFFF, 16'h0000));
        seq.push_back(sample_of(BTN_NONE,           1'b0, 16'hFFFF, 16'hFFFF));
        // stop mid-lift
        seq.push_back(sample_of(rmf_pkg::BTN_STOP,  1'b1, 16'h0000, 16'h0000));
        seq.push_back(sample_of(rmf_pkg::BTN_START, 1'b0, 16'h0000, 16'h0000));
        // stop from dark
        seq.push_back(sample_of(rmf_pkg::BTN_STOP,  1'b0, 16'h0000, 16'hFFFF));
        foreach (seq[i]) send_sample(seq[i]);
        drain_results();
    endtask

    // All thresholds at zero, then at full scale, then writes past the map.
    task automatic test_threshold_extremes();
        rmf_pkg::t_cfg c;
        c = '0;
        write_cfg(c);
        random_run(120);
        c = '1;
        write_cfg(c);
        random_run(120);
        write_reg(REG_COUNT, rmf_pkg::t_level'($urandom));
        write_reg(REG_FAR, rmf_pkg::t_level'($urandom));
        random_run(60);
    endtask

    // Defaults, fully random thresholds, and thresholds jittered around the
    // defaults with both sides streaming flat out.
    task automatic test_random_settings();
        rmf_pkg::t_cfg c;
        write_cfg(rmf_pkg::CFG_RESET);
        random_run(200);
        c = {$urandom, $urandom, $urandom, $urandom};
        write_cfg(c);
        random_run(150);
        c.light_out   = rmf_pkg::t_level'($urandom_range(0, 80));
        c.light_dim   = rmf_pkg::t_level'($urandom_range(60, 600));
        c.lift_start  = rmf_pkg::t_level'($urandom_range(16000, 18000));
        c.lift_peak   = rmf_pkg::t_level'($urandom_range(14500, 16000));
        c.lift_settle = rmf_pkg::t_level'($urandom_range(15500, 17000));
        c.drop_start  = rmf_pkg::t_level'($urandom_range(14500, 16000));
        c.drop_peak   = rmf_pkg::t_level'($urandom_range(16000, 18000));
        c.drop_settle = rmf_pkg::t_level'($urandom_range(15500, 17500));
        write_cfg(c);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        random_run(200);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing,
    // so both stages fill and the input stalls; then the sender waits it out.
    task automatic test_output_backpressure();
        write_cfg(rmf_pkg::CFG_RESET);
        rx_hold_req = 300;
        tx_gaps_on  = 1'b0;
        for (int i = 0; i < 40; i++) send_sample(make_sample(1'b0));
        tx_gaps_on  = 1'b1;
        drain_results();
        random_run(80);
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, in-order compare against predictions
    // ------------------------------------------------------------------
    initial begin : result_checker
        t_outcome want;
        int       stall_left;
        int       hold_left;
        stall_left = 0;
        hold_left  = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (!$isunknown(result_ch.mode)) modes_reached[result_ch.mode] = 1'b1;
                if (modes_due.size() == 0) begin
                    note_error($sformatf("word with nothing expected: mode %0d drive %0d",
                                         result_ch.mode, result_ch.drive_command));
                end else begin
                    want = modes_due.pop_front();
                    if (result_ch.mode !== want.mode)
                        note_error($sformatf("mode: expected %0d, actual %0d",
                                             want.mode, result_ch.mode));
                    if (result_ch.drive_command !== want.drive)
                        note_error($sformatf("drive_command: expected %0d, actual %0d",
                                             want.drive, result_ch.drive_command));
                end
            end
            // long hold-off requested by a test, counted here
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if (rx_stalls_on) stall_left = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        thr           = rmf_pkg::CFG_RESET;
        mode_now      = rmf_pkg::MODE_INACTIVE;
        errors        = 0;
        samples_sent  = 0;
        results_seen  = 0;
        reg_writes    = 0;
        cfg_sets      = 0;
        modes_reached = '0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        rx_hold_req   = 0;

        i_rst_n                  <= 1'b0;
        sample_ch.valid          <= 1'b0;
        sample_ch.button_code    <= BTN_NONE;
        sample_ch.bump_hit       <= 1'b0;
        sample_ch.light_level    <= '0;
        sample_ch.accel_vertical <= '0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= rmf_pkg::REG_LIGHT_OUT;
        cfg_ch.data              <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_modes();
        test_threshold_extremes();
        test_random_settings();
        test_output_backpressure();

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Summary: %0d samples in, %0d mode words out, %0d register writes,",
                 samples_sent, results_seen, reg_writes);
        $display("  %0d threshold sets; mode codes seen at the output (bit per code): %b",
                 cfg_sets, modes_reached[9:0]);
        if (errors == 0 && modes_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
